@@ rtl/tfn_pkg.sv @@
package tfn_pkg;

	localparam int DEFAULT_VERTEX_COUNT = 1024;
	localparam int IDX_W = 10;
	localparam int COORD_W = 16;
	localparam int NORM_W = 16;
	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 48;
	localparam int VTX_W = 3 * COORD_W;

	// action codes carried on the input tuser
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_FACE  = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0] norm_t;

endpackage

@@ rtl/triangle_face_normal_unit.sv @@
// vertex write: goes from idle straight to the result state, which registers the output word
// face: corners are read and crossed; a zero product goes straight to the result state,
// else a shift search scales it, then each of the three components runs a one-bit-per-cycle
// restoring divide (31 bits) and square root (16 bits), root trials on one shared multiplier
// a held result stalls the unit in its last state; one item is in flight at a time
// arst_n clears control and the output valid; the vertex memory is not cleared
module triangle_face_normal_unit
	import tfn_pkg::*;
#(
	parameter int VERTEX_COUNT = DEFAULT_VERTEX_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// index_a, index_b, index_c, pos_x, pos_y, pos_z, 2 bits zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// action
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// normal_x, normal_y, normal_z
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// degenerate
	output logic                   m_tuser
);

	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_RDC  = 4'd3;
	localparam logic [3:0] S_RDW  = 4'd4;
	localparam logic [3:0] S_SUB  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_ABS  = 4'd7;
	localparam logic [3:0] S_SHF  = 4'd8;
	localparam logic [3:0] S_SQ   = 4'd9;
	localparam logic [3:0] S_DIVI = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_SQRT = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	logic [VTX_W-1:0] mem [VERTEX_COUNT];

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;

	logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_ok, rd_ok_q;
	logic [VTX_W-1:0] rd_data_q, rd_vtx;

	coord_t pa_q [3];
	coord_t pb_q [3];
	logic signed [16:0] u_q [3];
	logic signed [16:0] v_q [3];
	logic signed [34:0] cr_q [3];
	logic [33:0] mag_q [3];
	logic [31:0] s_q;
	logic [32:0] rem_q;
	logic        lowbit_q;
	logic [30:0] d_q;
	logic [15:0] root_q;
	norm_t       norm_q [3];
	logic        deg_q;

	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mul_p;

	logic [32:0] div_trial;
	logic        div_ge;
	logic [15:0] sq_trial, sq_root;
	logic        sq_keep;
	logic [14:0] q_mag;

	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic          any_big;
	logic          accept;

	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic m_tuser_q;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign wr_addr = AW'(s_tdata[IDX_W-1:0]);
	assign wr_en   = accept && (s_tuser == ACT_WRITE)
		&& ({7'd0, s_tdata[IDX_W-1:0]} < 17'(VERTEX_COUNT));

	always_comb begin
		case (state_q)
			S_RDA:   rd_idx = idx_a_q;
			S_RDB:   rd_idx = idx_b_q;
			default: rd_idx = idx_c_q;
		endcase
		rd_ok = ({7'd0, rd_idx} < 17'(VERTEX_COUNT));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= s_tdata[IN_TDATA_W-3:3*IDX_W];
		end
		rd_data_q <= mem[AW'(rd_idx)];
		rd_ok_q   <= rd_ok;
	end

	// corners beyond the store read as the origin
	assign rd_vtx = rd_ok_q ? rd_data_q : '0;

	// one shared multiplier: cross terms, squares, dividend setup, root trials
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				case (cnt_q[2:0])
					3'd0:    begin mul_a = 18'(u_q[1]); mul_b = 18'(v_q[2]); end
					3'd1:    begin mul_a = 18'(u_q[2]); mul_b = 18'(v_q[1]); end
					3'd2:    begin mul_a = 18'(u_q[2]); mul_b = 18'(v_q[0]); end
					3'd3:    begin mul_a = 18'(u_q[0]); mul_b = 18'(v_q[2]); end
					3'd4:    begin mul_a = 18'(u_q[0]); mul_b = 18'(v_q[1]); end
					default: begin mul_a = 18'(u_q[1]); mul_b = 18'(v_q[0]); end
				endcase
			end
			S_SQ: begin
				mul_a = {3'd0, mag_q[cnt_q[1:0]][14:0]};
				mul_b = {3'd0, mag_q[cnt_q[1:0]][14:0]};
			end
			S_DIVI: begin
				mul_a = {3'd0, mag_q[comp_q][14:0]};
				mul_b = {3'd0, mag_q[comp_q][14:0]};
			end
			S_SQRT: begin
				mul_a = {2'd0, sq_trial};
				mul_b = {2'd0, sq_trial};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign div_trial = {rem_q[31:0], (cnt_q == 5'd0) ? lowbit_q : 1'b0};
	assign div_ge    = (div_trial >= {1'b0, s_q});
	assign sq_trial  = root_q | (16'd1 << cnt_q[3:0]);
	assign sq_keep   = ($unsigned(mul_p) <= {5'd0, d_q});
	assign sq_root   = sq_keep ? sq_trial : root_q;
	assign q_mag     = 15'(({1'b0, sq_root} + 17'd1) >> 1);

	assign any_big = (mag_q[0][33:15] != '0) || (mag_q[1][33:15] != '0)
		|| (mag_q[2][33:15] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == ACT_FACE) ? S_RDA : S_FIN;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_RDC;
				S_RDC: state_q <= S_RDW;
				S_RDW: state_q <= S_SUB;
				S_SUB: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					if (cnt_q == 5'd5) begin
						state_q <= S_ABS;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_ABS: begin
					state_q <= ((cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0))
						? S_FIN : S_SHF;
				end
				S_SHF: begin
					if (!any_big) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					if (cnt_q == 5'd2) begin
						state_q <= S_DIVI;
						comp_q  <= '0;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_DIVI: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == 5'd30) begin
						state_q <= S_SQRT;
						cnt_q   <= 5'd15;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 5'd0) begin
						if (comp_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIVI;
							comp_q  <= comp_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_a_q <= s_tdata[IDX_W-1:0];
				idx_b_q <= s_tdata[2*IDX_W-1:IDX_W];
				idx_c_q <= s_tdata[3*IDX_W-1:2*IDX_W];
				deg_q   <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					norm_q[i] <= '0;
				end
			end
			S_RDB: begin
				for (int i = 0; i < 3; i++) begin
					pa_q[i] <= rd_vtx[i*COORD_W +: COORD_W];
				end
			end
			S_RDC: begin
				for (int i = 0; i < 3; i++) begin
					pb_q[i] <= rd_vtx[i*COORD_W +: COORD_W];
				end
			end
			S_RDW: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= 17'(coord_t'(rd_vtx[i*COORD_W +: COORD_W])) - 17'(pb_q[i]);
				end
			end
			S_SUB: begin
				for (int i = 0; i < 3; i++) begin
					v_q[i]  <= 17'(pa_q[i]) - 17'(pb_q[i]);
					cr_q[i] <= '0;
				end
			end
			S_MUL: begin
				if (cnt_q[0]) begin
					cr_q[cnt_q[2:1]] <= cr_q[cnt_q[2:1]] - 35'(mul_p);
				end else begin
					cr_q[cnt_q[2:1]] <= cr_q[cnt_q[2:1]] + 35'(mul_p);
				end
			end
			S_ABS: begin
				deg_q <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= cr_q[i][34] ? 34'(-cr_q[i]) : 34'(cr_q[i]);
				end
				s_q <= '0;
			end
			S_SHF: begin
				if (any_big) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			S_SQ: s_q <= s_q + 32'(mul_p);
			S_DIVI: begin
				// dividend is m^2 * 2^30, its low zeros are fed in by the divide steps
				rem_q    <= {4'd0, mul_p[29:1]};
				lowbit_q <= mul_p[0];
				d_q      <= '0;
				root_q   <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? (div_trial - {1'b0, s_q}) : div_trial;
				d_q   <= {d_q[29:0], div_ge};
			end
			S_SQRT: begin
				root_q <= sq_root;
				if (cnt_q == 5'd0) begin
					norm_q[comp_q] <= cr_q[comp_q][34] ? -NORM_W'(q_mag) : NORM_W'(q_mag);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_FIN) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {norm_q[2], norm_q[1], norm_q[0]};
			m_tuser_q <= deg_q;
		end
	end

`ifndef SYNTHESIS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate word carries a nonzero normal");

	a_write_fin: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_WRITE) |=> state_q == S_FIN)
		else $error("vertex write did not go straight to result");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= 5'd30 && comp_q != 2'd3)
		else $error("divide step count out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && $past(state_q) == S_DIV |-> rem_q < {1'b0, s_q})
		else $error("divide remainder not below divisor");
`endif

endmodule

@@ tb/sv/face_normal_checker.sv @@
module face_normal_checker
	import tfn_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tuser,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		norm_t nx;
		norm_t ny;
		norm_t nz;
		logic  degen;
	} normal_word_t;

	coord_t vert_x [DEFAULT_VERTEX_COUNT];
	coord_t vert_y [DEFAULT_VERTEX_COUNT];
	coord_t vert_z [DEFAULT_VERTEX_COUNT];
	normal_word_t expected_normals [$];

	// largest q with (2q-1)^2 * s <= m^2 * 2^30
	function automatic longint unsigned unit_length_mag(longint unsigned m,
			longint unsigned s);
		longint unsigned rhs, lo, hi, mid, t;
		rhs = (m * m) << 30;
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t = 2 * mid - 1;
			if (t * t * s <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic normal_word_t face_normal(int ia, int ib, int ic);
		normal_word_t r;
		longint u [3], v [3], cr [3];
		longint unsigned mag [3], maxm, s, q;
		int sh;
		u[0] = longint'(vert_x[ic]) - longint'(vert_x[ib]);
		u[1] = longint'(vert_y[ic]) - longint'(vert_y[ib]);
		u[2] = longint'(vert_z[ic]) - longint'(vert_z[ib]);
		v[0] = longint'(vert_x[ia]) - longint'(vert_x[ib]);
		v[1] = longint'(vert_y[ia]) - longint'(vert_y[ib]);
		v[2] = longint'(vert_z[ia]) - longint'(vert_z[ib]);
		cr[0] = u[1] * v[2] - u[2] * v[1];
		cr[1] = u[2] * v[0] - u[0] * v[2];
		cr[2] = u[0] * v[1] - u[1] * v[0];
		r = '0;
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
			r.degen = 1'b1;
			return r;
		end
		maxm = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? $unsigned(-cr[i]) : $unsigned(cr[i]);
			if (mag[i] > maxm)
				maxm = mag[i];
		end
		sh = 0;
		while ((maxm >> sh) >= 32768)
			sh++;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = mag[i] >> sh;
			s += mag[i] * mag[i];
		end
		for (int i = 0; i < 3; i++) begin
			q = unit_length_mag(mag[i], s);
			if (cr[i] < 0)
				q = (64'h10000 - q) & 64'hFFFF;
			case (i)
				0: r.nx = norm_t'(q[15:0]);
				1: r.ny = norm_t'(q[15:0]);
				default: r.nz = norm_t'(q[15:0]);
			endcase
		end
		return r;
	endfunction

	// sampled at the falling edge; a word moves at the next rising edge
	always @(negedge clk) begin
		normal_word_t got, want;
		int ia, ib, ic;
		if (arst_n && s_tvalid && s_tready) begin
			ia = s_tdata[9:0];
			ib = s_tdata[19:10];
			ic = s_tdata[29:20];
			if (s_tuser == ACT_WRITE) begin
				if (ia < DEFAULT_VERTEX_COUNT) begin
					vert_x[ia] = s_tdata[45:30];
					vert_y[ia] = s_tdata[61:46];
					vert_z[ia] = s_tdata[77:62];
				end
				want = '0;
			end else begin
				want = face_normal(ia, ib, ic);
			end
			expected_normals = {expected_normals, want};
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.nx = m_tdata[15:0];
			got.ny = m_tdata[31:16];
			got.nz = m_tdata[47:32];
			got.degen = m_tuser;
			if (expected_normals.size() == 0) begin
				errors++;
				$display("%0t: unexpected word nx=%0d ny=%0d nz=%0d degen=%0b", $time,
					got.nx, got.ny, got.nz, got.degen);
			end else begin
				want = expected_normals.pop_front();
				if (got != want) begin
					errors++;
					$display("%0t: expected nx=%0d ny=%0d nz=%0d degen=%0b,",
						$time, want.nx, want.ny, want.nz, want.degen,
						" got nx=%0d ny=%0d nz=%0d degen=%0b",
						got.nx, got.ny, got.nz, got.degen);
				end
			end
		end
		pending = expected_normals.size();
	end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import tfn_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int STALL_LIMIT = 4000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	int                     errors;
	int                     pending;
	int                     idle_cycles;
	int                     rx_cycle;
	int                     item_no;
	int                     written [$];

	triangle_face_normal_unit uut (.*);

	face_normal_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stalls, one long hold-off, then a stretch with none
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle >= 3000 && rx_cycle < 3400)
			m_tready <= 1'b0;
		else if (rx_cycle >= 8000 && rx_cycle < 14000)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 21);
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (++idle_cycles >= STALL_LIMIT) begin
			$display("triangle_face_normal_unit test failed");
			$finish;
		end
	end

	task automatic send_word(logic act, int ia, int ib, int ic,
			logic [15:0] px, logic [15:0] py, logic [15:0] pz);
		if ($urandom_range(99) < 21 && !(item_no >= 200 && item_no < 320)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {2'b00, pz, py, px, ic[9:0], ib[9:0], ia[9:0]};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		if (act == ACT_WRITE && !(ia inside {written}))
			written = {written, ia};
		item_no++;
	endtask

	function automatic logic [15:0] rand_coord();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'($urandom_range(1023) - 512);
	endfunction

	function automatic int pick_vertex();
		return written[$urandom_range(written.size() - 1)];
	endfunction

	initial begin
		int a, b, c;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = ACT_WRITE;
		s_tdata = '0;
		item_no = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_WRITE, 0, 1023, 1023, 16'h8000, 16'h8000, 16'h8000);
		send_word(ACT_WRITE, 1, 0, 0, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_word(ACT_WRITE, 2, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_word(ACT_WRITE, 1023, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_word(ACT_WRITE, 512, 0, 0, 16'd256, 16'd0, 16'd0);
		send_word(ACT_WRITE, 513, 0, 0, 16'd0, 16'd256, 16'd0);
		send_word(ACT_WRITE, 514, 0, 0, 16'd0, 16'd0, 16'd256);
		send_word(ACT_WRITE, 3, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(ACT_WRITE, 4, 0, 0, 16'd1, 16'd1, 16'd1);
		send_word(ACT_WRITE, 5, 0, 0, 16'd2, 16'd2, 16'd2);
		send_word(ACT_FACE, 0, 1, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(ACT_FACE, 2, 1, 0, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 1023, 0, 1, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 512, 513, 514, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 514, 513, 512, 16'h0, 16'h0, 16'h0);
		// degenerate: one point, collinear points, two equal corners
		send_word(ACT_FACE, 512, 512, 512, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 3, 4, 5, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 512, 513, 512, 16'h0, 16'h0, 16'h0);
		send_word(ACT_FACE, 1023, 1023, 0, 16'h0, 16'h0, 16'h0);

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(99) < 45) begin
				a = pick_vertex();
				b = pick_vertex();
				c = pick_vertex();
				if ($urandom_range(9) == 0)
					c = a;
				send_word(ACT_FACE, a, b, c, rand_coord(), rand_coord(), rand_coord());
			end else begin
				a = $urandom_range(2) == 0 ? $urandom_range(1023) : $urandom_range(31);
				send_word(ACT_WRITE, a, $urandom_range(1023), $urandom_range(1023),
					rand_coord(), rand_coord(), rand_coord());
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("triangle_face_normal_unit test passed");
		else
			$display("triangle_face_normal_unit test failed");
		$finish;
	end

endmodule
